// ----- sv/ostt_pkg.sv -----
// ----------------------------------------------------------------------------
// ostt_pkg
// Shared types, sizes and codes of the one-shot timer table.
// ----------------------------------------------------------------------------
package ostt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 3 * WORD_W;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [2:0] RES_NONE    = 3'd0;
    localparam logic [2:0] RES_REJECT  = 3'd1;
    localparam logic [2:0] RES_FULL    = 3'd2;
    localparam logic [2:0] RES_CREATED = 3'd3;
    localparam logic [2:0] RES_FIRED   = 3'd4;

    typedef struct packed {
        logic       load;
        logic       create;
        logic       delete_slot;
        logic       tick;
        logic       scan_clr;
        logic       scan_inc;
        logic       fire;
        logic       emit;
        logic [2:0] res;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       reject;
        logic       full;
        logic       hit;
        logic       last;
    } t_dp_stat;

endpackage

// ----- sv/one_shot_timer_table.sv -----
// ----------------------------------------------------------------------------
// one_shot_timer_table
// Table of one-shot timers with create, delete and tick requests.
//
// A request is taken at a rising edge with start high and busy low. Exactly
// one result follows: o_strobe is high for one cycle with the result fields,
// and the receiver must take it then; it cannot stall the block.
// Create, delete and unused op codes: the result is decided in the execute
// state and registered onto the outputs. Tick: the slot scan reads one slot
// per cycle from the slot RAM and stops at the first due slot. busy falls
// as the strobe rises, so the next request can be taken in the strobe
// cycle. The free-slot search works on per-slot valid flops; slot RAM
// contents only count for valid slots.
// Reset clears the tick counter and frees every slot at once; no clearing
// pass is needed and a request may follow in the first cycle after reset.
// ----------------------------------------------------------------------------
module one_shot_timer_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic [ostt_pkg::WORD_W-1:0] i_handler_tag,
    input  logic [ostt_pkg::WORD_W-1:0] i_callback_arg,
    input  logic [ostt_pkg::WORD_W-1:0] i_timeout_ticks,
    input  logic [3:0]                  i_slot_index,
    output logic                        o_strobe,
    output logic [1:0]                  o_status,
    output logic [3:0]                  o_result_slot,
    output logic                        o_fired,
    output logic [ostt_pkg::WORD_W-1:0] o_fired_handler,
    output logic [ostt_pkg::WORD_W-1:0] o_fired_arg,
    output logic [ostt_pkg::WORD_W-1:0] o_tick_now
);

    ostt_pkg::t_dp_cmd  cmd;
    ostt_pkg::t_dp_stat stat;

    ostt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ostt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_handler_tag   (i_handler_tag),
        .i_callback_arg  (i_callback_arg),
        .i_timeout_ticks (i_timeout_ticks),
        .i_slot_index    (i_slot_index),
        .o_stat          (stat),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_result_slot   (o_result_slot),
        .o_fired         (o_fired),
        .o_fired_handler (o_fired_handler),
        .o_fired_arg     (o_fired_arg),
        .o_tick_now      (o_tick_now)
    );

endmodule

// ----- sv/ostt_ram.sv -----
// ----------------------------------------------------------------------------
// ostt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ostt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ostt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ostt_ctrl
// Sequencer of the timer table: decodes each request and steps the slot scan.
// ----------------------------------------------------------------------------
module ostt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ostt_pkg::t_dp_stat i_stat,
    output ostt_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.op)
                    ostt_pkg::OP_CREATE: begin
                        o_cmd.emit = 1'b1;
                        if (i_stat.reject) begin
                            o_cmd.res = ostt_pkg::RES_REJECT;
                        end else if (i_stat.full) begin
                            o_cmd.res = ostt_pkg::RES_FULL;
                        end else begin
                            o_cmd.create = 1'b1;
                            o_cmd.res    = ostt_pkg::RES_CREATED;
                        end
                    end
                    ostt_pkg::OP_DELETE: begin
                        o_cmd.delete_slot = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.res         = ostt_pkg::RES_NONE;
                    end
                    ostt_pkg::OP_TICK: begin
                        o_cmd.tick     = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_READ;
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.res  = ostt_pkg::RES_NONE;
                    end
                endcase
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    o_cmd.fire = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.res  = ostt_pkg::RES_FIRED;
                    n_state    = S_IDLE;
                end else if (i_stat.last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.res  = ostt_pkg::RES_NONE;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- sv/ostt_dpath.sv -----
// ----------------------------------------------------------------------------
// ostt_dpath
// Slot storage, tick counter, free-slot search, deadline compare and
// result registers of the timer table.
// ----------------------------------------------------------------------------
module ostt_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ostt_pkg::t_dp_cmd               i_cmd,
    input  logic [1:0]                      i_op,
    input  logic [ostt_pkg::WORD_W-1:0]     i_handler_tag,
    input  logic [ostt_pkg::WORD_W-1:0]     i_callback_arg,
    input  logic [ostt_pkg::WORD_W-1:0]     i_timeout_ticks,
    input  logic [3:0]                      i_slot_index,
    output ostt_pkg::t_dp_stat              o_stat,
    output logic                            o_strobe,
    output logic [1:0]                      o_status,
    output logic [3:0]                      o_result_slot,
    output logic                            o_fired,
    output logic [ostt_pkg::WORD_W-1:0]     o_fired_handler,
    output logic [ostt_pkg::WORD_W-1:0]     o_fired_arg,
    output logic [ostt_pkg::WORD_W-1:0]     o_tick_now
);

    localparam int NS = ostt_pkg::NUM_SLOTS;
    localparam int SW = ostt_pkg::SLOT_W;
    localparam int WW = ostt_pkg::WORD_W;

    // request registers
    logic [1:0]    r_op;
    logic [WW-1:0] r_handler;
    logic [WW-1:0] r_arg;
    logic [WW-1:0] r_timeout;
    logic [3:0]    r_idx;

    logic [NS-1:0] r_valid;
    logic [WW-1:0] r_tick;
    logic [SW-1:0] r_scan;
    logic          r_strobe;

    logic [1:0]    r_status;
    logic [3:0]    r_slot;
    logic          r_fired;
    logic [WW-1:0] r_fhandler;
    logic [WW-1:0] r_farg;
    logic [WW-1:0] r_tick_now;

    logic [SW-1:0] free_idx;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] del_idx;
    logic          del_ok;
    logic [ostt_pkg::ENTRY_W-1:0] wr_data;
    logic [ostt_pkg::ENTRY_W-1:0] rd_data;
    logic [WW-1:0] rd_handler;
    logic [WW-1:0] rd_arg;
    logic [WW-1:0] rd_deadline;

    logic [1:0]    n_status;
    logic [3:0]    n_slot;
    logic          n_fired;
    logic [WW-1:0] n_fhandler;
    logic [WW-1:0] n_farg;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SW'(i);
            end
        end
    end

    assign rd_addr = i_cmd.scan_inc ? (r_scan + SW'(1)) : r_scan;
    assign wr_data = {r_handler, r_arg, r_tick + r_timeout};
    assign {rd_handler, rd_arg, rd_deadline} = rd_data;
    assign del_idx = SW'(r_idx);
    assign del_ok  = (7'(r_idx) < 7'(NS));

    ostt_ram #(
        .WIDTH (ostt_pkg::ENTRY_W),
        .DEPTH (NS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.create),
        .i_waddr (free_idx),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_stat.op     = r_op;
        o_stat.reject = (r_handler == '0) || (r_timeout == '0);
        o_stat.full   = &r_valid;
        o_stat.hit    = r_valid[r_scan] && (r_tick >= rd_deadline);
        o_stat.last   = (r_scan == SW'(NS - 1));
    end

    always_comb begin
        n_status   = ostt_pkg::ST_OK;
        n_slot     = '0;
        n_fired    = 1'b0;
        n_fhandler = '0;
        n_farg     = '0;
        unique case (i_cmd.res)
            ostt_pkg::RES_REJECT: begin
                n_status = ostt_pkg::ST_REJECT;
            end
            ostt_pkg::RES_FULL: begin
                n_status = ostt_pkg::ST_FULL;
            end
            ostt_pkg::RES_CREATED: begin
                n_slot = 4'(free_idx);
            end
            ostt_pkg::RES_FIRED: begin
                n_slot     = 4'(r_scan);
                n_fired    = 1'b1;
                n_fhandler = rd_handler;
                n_farg     = rd_arg;
            end
            default: begin
                n_status = ostt_pkg::ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_tick   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.tick) begin
                r_tick <= r_tick + WW'(1);
            end
            if (i_cmd.create) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (i_cmd.delete_slot && del_ok) begin
                r_valid[del_idx] <= 1'b0;
            end
            if (i_cmd.fire) begin
                r_valid[r_scan] <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_handler <= i_handler_tag;
            r_arg     <= i_callback_arg;
            r_timeout <= i_timeout_ticks;
            r_idx     <= i_slot_index;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + SW'(1);
        end
        if (i_cmd.emit) begin
            r_status   <= n_status;
            r_slot     <= n_slot;
            r_fired    <= n_fired;
            r_fhandler <= n_fhandler;
            r_farg     <= n_farg;
            r_tick_now <= r_tick;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_result_slot   = r_slot;
    assign o_fired         = r_fired;
    assign o_fired_handler = r_fhandler;
    assign o_fired_arg     = r_farg;
    assign o_tick_now      = r_tick_now;

endmodule
